[rtl/dthp_pkg.sv]
package dthp_pkg;

    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int TIME_W     = 16;
    localparam int DIST_W     = 16;
    localparam int WIRE_W     = 22;
    localparam int HIT_W      = 23;
    localparam int SIDE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int LAYER_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam int ENTRY_W    = TIME_W + DIST_W;
    localparam int PROD_W     = TIME_W + DIST_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int SCALE_W    = 17;
    localparam int SCL_PROD_W = DIST_W + SCALE_W;
    localparam int SCALED_W   = SCL_PROD_W - 16;

    localparam logic [SCALE_W-1:0]    STEREO_Q16 = 17'd66547;
    localparam logic [SCL_PROD_W-1:0] SCL_ROUND  = SCL_PROD_W'(32768);

    localparam logic [CFG_IDX_W-1:0]  CFG_LAYER     = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_POINTS    = 1'b1;
    localparam logic [LAYER_W-1:0]    LAYER_RESET   = 3'd1;
    localparam logic [CNT_W-1:0]      POINTS_RESET  = CNT_W'(2);
    localparam logic [SIDE_W-1:0]     SIDE_PLUS     = 2'b01;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONV  = 2'd0,
        ST_MISS  = 2'd1,
        ST_WRITE = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REQ_WRITE = 1'b0,
        REQ_HIT   = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN,
        S_SCL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                     req_type;
        logic [4:0]               point_index;
        logic [TIME_W-1:0]        point_time;
        logic [DIST_W-1:0]        point_distance;
        logic signed [WIRE_W-1:0] wire_x;
        logic [TIME_W-1:0]        hit_time;
        logic signed [SIDE_W-1:0] side;
    } t_in_item;

    typedef struct packed {
        logic signed [HIT_W-1:0] hit_x;
        logic [DIST_W-1:0]       wire_hit_distance;
        logic [STATUS_W-1:0]     status;
    } t_out_item;

    typedef struct packed {
        logic    wr;
        logic    load;
        logic    rd_first;
        logic    rd_next;
        logic    mul;
        logic    div_step;
        logic    fin;
        logic    scl;
        logic    out_load;
        t_status out_code;
    } t_cmd;

    typedef struct packed {
        logic seg_hit;
        logic last_pt;
        logic div_last;
        logic out_free;
    } t_sts;

    function automatic logic is_stereo(input logic [LAYER_W-1:0] layer);
        logic r;
        r = 1'b0;
        if (layer inside {3'd2, 3'd3, 3'd5, 3'd6}) begin
            r = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/dthp_if.sv]
interface dthp_in_if;
    import dthp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [4:0]               point_index;
    logic [TIME_W-1:0]        point_time;
    logic [DIST_W-1:0]        point_distance;
    logic signed [WIRE_W-1:0] wire_x;
    logic [TIME_W-1:0]        hit_time;
    logic signed [SIDE_W-1:0] side;

    modport source (
        output valid, req_type, point_index, point_time, point_distance,
               wire_x, hit_time, side,
        input  ready
    );

    modport sink (
        input  valid, req_type, point_index, point_time, point_distance,
               wire_x, hit_time, side,
        output ready
    );
endinterface

interface dthp_out_if;
    import dthp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [HIT_W-1:0] hit_x;
    logic [DIST_W-1:0]       wire_hit_distance;
    logic [STATUS_W-1:0]     status;

    modport source (
        output valid, hit_x, wire_hit_distance, status,
        input  ready
    );

    modport sink (
        input  valid, hit_x, wire_hit_distance, status,
        output ready
    );
endinterface

[rtl/dthp_ctrl.sv]
module dthp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  dthp_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output dthp_pkg::t_cmd o_cmd
);
    import dthp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_WRITE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_code = r_code;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == REQ_WRITE) begin
                        o_cmd.wr = 1'b1;
                        n_code   = ST_WRITE;
                        n_state  = S_OUT;
                    end else begin
                        o_cmd.load     = 1'b1;
                        o_cmd.rd_first = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.seg_hit) begin
                    n_state = S_MUL;
                end else if (i_sts.last_pt) begin
                    n_code  = ST_MISS;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_SCL;
            end
            S_SCL: begin
                o_cmd.scl = 1'b1;
                n_code    = ST_CONV;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[rtl/dthp_datapath.sv]
module dthp_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [dthp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dthp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  dthp_pkg::t_in_item                   i_item,
    input  dthp_pkg::t_cmd                       i_cmd,
    input  logic                                 i_out_ready,
    output dthp_pkg::t_sts                       o_sts,
    output logic                                 o_out_valid,
    output dthp_pkg::t_out_item                  o_out_item
);
    import dthp_pkg::*;

    logic [ENTRY_W-1:0]       r_mem [MAX_POINTS];
    logic [ENTRY_W-1:0]       r_rd;
    logic [ENTRY_W-1:0]       r_prev;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         w_rd_addr;

    logic [LAYER_W-1:0]       r_layer;
    logic [CNT_W-1:0]         r_points;
    logic [CNT_W-1:0]         w_n_sat;

    logic [TIME_W-1:0]        r_time;
    logic signed [WIRE_W-1:0] r_wire;
    logic [SIDE_W-1:0]        r_side;

    logic [PROD_W-1:0]        r_quo;
    logic [TIME_W-1:0]        r_den;
    logic [TIME_W-1:0]        r_rem;
    logic                     r_neg;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic [DIST_W-1:0]        r_dist;
    logic [SCALED_W-1:0]      r_scaled;

    logic                     r_ovalid;
    t_out_item                r_out;

    logic [TIME_W-1:0]        w_cur_t;
    logic [TIME_W-1:0]        w_prev_t;
    logic [DIST_W-1:0]        w_cur_x;
    logic [DIST_W-1:0]        w_prev_x;
    logic [DIST_W:0]          w_dx;
    logic [DIST_W:0]          w_dx_mag;
    logic [TIME_W-1:0]        w_dt;
    logic [TIME_W:0]          w_rem_sh;
    logic [TIME_W:0]          w_rem_sub;
    logic                     w_ge;
    logic [DIST_W-1:0]        w_q;
    logic [SCL_PROD_W-1:0]    w_scl_prod;
    logic [HIT_W-1:0]         w_wire_ext;
    logic [HIT_W-1:0]         w_sc_ext;
    logic [HIT_W-1:0]         w_hit;

    assign w_cur_t  = r_rd[ENTRY_W-1:DIST_W];
    assign w_cur_x  = r_rd[DIST_W-1:0];
    assign w_prev_t = r_prev[ENTRY_W-1:DIST_W];
    assign w_prev_x = r_prev[DIST_W-1:0];

    assign w_n_sat   = (r_points > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_points;
    assign w_rd_addr = i_cmd.rd_first ? '0 : r_idx + IDX_W'(1);

    assign o_sts.seg_hit  = (r_idx != '0) && (r_time >= w_prev_t) && (r_time < w_cur_t);
    assign o_sts.last_pt  = (CNT_W'(r_idx) + CNT_W'(1)) >= w_n_sat;
    assign o_sts.div_last = r_cnt == DIV_CNT_W'(PROD_W - 1);
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    assign w_dx     = {1'b0, w_cur_x} - {1'b0, w_prev_x};
    assign w_dx_mag = w_dx[DIST_W] ? (~w_dx + 1'b1) : w_dx;
    assign w_dt     = r_time - w_prev_t;

    assign w_rem_sh  = {r_rem, r_quo[PROD_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_q       = r_quo[DIST_W-1:0];

    assign w_scl_prod = SCL_PROD_W'(r_dist) * SCL_PROD_W'(STEREO_Q16) + SCL_ROUND;

    assign w_wire_ext = {r_wire[WIRE_W-1], r_wire};
    assign w_sc_ext   = HIT_W'(r_scaled);

    always_comb begin
        if (r_side == SIDE_PLUS) begin
            w_hit = w_wire_ext + w_sc_ext;
        end else if (r_side[SIDE_W-1]) begin
            w_hit = w_wire_ext - w_sc_ext;
        end else begin
            w_hit = w_wire_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer  <= LAYER_RESET;
            r_points <= POINTS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LAYER:  r_layer  <= i_cfg_data[LAYER_W-1:0];
                CFG_POINTS: r_points <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_item.point_index[IDX_W-1:0]] <= {i_item.point_time, i_item.point_distance};
        end
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time <= i_item.hit_time;
            r_wire <= i_item.wire_x;
            r_side <= i_item.side;
        end
        if (i_cmd.rd_first) begin
            r_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_idx  <= r_idx + IDX_W'(1);
            r_prev <= r_rd;
        end
        if (i_cmd.mul) begin
            r_quo <= PROD_W'(w_dx_mag[DIST_W-1:0]) * PROD_W'(w_dt);
            r_den <= w_cur_t - w_prev_t;
            r_neg <= w_dx[DIST_W];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[TIME_W-1:0] : w_rem_sh[TIME_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.fin) begin
            r_dist <= r_neg ? (w_prev_x - w_q) : (w_prev_x + w_q);
        end
        if (i_cmd.scl) begin
            r_scaled <= is_stereo(r_layer) ? w_scl_prod[SCL_PROD_W-1:16]
                                           : SCALED_W'(r_dist);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status <= i_cmd.out_code;
            if (i_cmd.out_code == ST_CONV) begin
                r_out.hit_x             <= w_hit;
                r_out.wire_hit_distance <= r_dist;
            end else begin
                r_out.hit_x             <= '0;
                r_out.wire_hit_distance <= '0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
endmodule

[rtl/drift_time_to_hit_position.sv]
// Drift-time to hit-position converter for one drift-chamber layer.
// Items enter on i_in (valid/ready) and one result per item leaves on o_out.
// A write item (req_type 0) stores one (time, distance) breakpoint and
// then loads its status 2 result once the output register is free.
// A hit item (req_type 1) scans the breakpoint table one entry per cycle
// through the table memory's single registered read port, then multiplies,
// runs a 32-step restoring divider at one quotient bit per cycle, and scales
// stereo layers. A time outside the table returns status 1.
// One item is worked on at a time; i_in.ready is high only while idle.
// The result sits in an output register; the next item may be accepted while
// it waits, and a later result waits for that register to be taken.
// The user must write layer_number (index 0) and points_in_use (index 1)
// on the configuration port while the block is idle; it is not enforced.
// Synchronous reset sets layer_number to 1, points_in_use to 2 and clears
// the output valid; the breakpoint table is undefined until written.
module drift_time_to_hit_position (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [dthp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dthp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dthp_in_if.sink                         i_in,
    dthp_out_if.source                      o_out
);
    import dthp_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    t_in_item  w_item;
    t_out_item w_out_item;
    logic      w_in_ready;
    logic      w_out_valid;

    assign w_item.req_type       = i_in.req_type;
    assign w_item.point_index    = i_in.point_index;
    assign w_item.point_time     = i_in.point_time;
    assign w_item.point_distance = i_in.point_distance;
    assign w_item.wire_x         = i_in.wire_x;
    assign w_item.hit_time       = i_in.hit_time;
    assign w_item.side           = i_in.side;

    assign i_in.ready              = w_in_ready;
    assign o_out.valid             = w_out_valid;
    assign o_out.hit_x             = w_out_item.hit_x;
    assign o_out.wire_hit_distance = w_out_item.wire_hit_distance;
    assign o_out.status            = w_out_item.status;

    dthp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    dthp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded while the output register was still occupied");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("new item accepted while the previous one was in progress");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_CONV))
            |-> (o_out.hit_x == '0) && (o_out.wire_hit_distance == '0))
        else $error("write or miss result carries nonzero fields");
`endif
endmodule
